[rtl/u2h_pkg.sv]
// Shared types and constants for the UTF-8 to hex UCS-2 encoder.
// No dependencies; used by u2h_decode, u2h_serialize and utf8_to_ucs2_hex_core.
package u2h_pkg;

   localparam int unsigned UNIT_W   = 16;
   localparam int unsigned CHAR_W   = 7;
   localparam int unsigned NIB_CNT_W = 4;   // holds 0..8 nibbles

   localparam logic [7:0]        ASCII_LIMIT = 8'h80;
   localparam logic [UNIT_W-1:0] QMARK_UNIT  = 16'h003F;

   // Number of code units produced by one input byte
   typedef enum logic [1:0] {
      UNITS_NONE = 2'd0,
      UNITS_ONE  = 2'd1,
      UNITS_TWO  = 2'd2
   } units_type;

   typedef struct packed {
      units_type         units;
      logic [UNIT_W-1:0] unit0;   // emitted first
      logic [UNIT_W-1:0] unit1;
   } dec_result_type;

   typedef struct packed {
      logic                 out_free;
      logic [NIB_CNT_W-1:0] nib_left;
   } ser_status_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] ext;
      ext = {3'b000, nib};
      if (nib < 4'd10) begin
         hex_char = ext + 7'h30;
      end else begin
         hex_char = ext + 7'h37;
      end
   endfunction

   function automatic logic is_multi_lead(input logic [7:0] b);
      is_multi_lead = ((b & 8'hE0) == 8'hC0) || ((b & 8'hF0) == 8'hE0);
   endfunction

endpackage

[rtl/u2h_decode.sv]
// Sequence decoder: holds partial UTF-8 sequences and turns each accepted byte
// into zero, one or two 16-bit code units. Depends on u2h_pkg.
module u2h_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output u2h_pkg::dec_result_type result
);

   logic [7:0] held_lead_ff, held_lead_in;
   logic [7:0] held_second_ff, held_second_in;
   logic [1:0] held_count_ff, held_count_in;

   always_comb begin
      result.units   = u2h_pkg::UNITS_NONE;
      result.unit0   = '0;
      result.unit1   = '0;
      held_lead_in   = held_lead_ff;
      held_second_in = held_second_ff;
      held_count_in  = held_count_ff;
      case (held_count_ff)
         2'd0: begin
            if (in_byte < u2h_pkg::ASCII_LIMIT) begin
               result.units = u2h_pkg::UNITS_ONE;
               result.unit0 = {8'h00, in_byte};
            end else if (u2h_pkg::is_multi_lead(in_byte) && !in_last) begin
               held_lead_in  = in_byte;
               held_count_in = 2'd1;
            end else begin
               result.units = u2h_pkg::UNITS_ONE;
               result.unit0 = u2h_pkg::QMARK_UNIT;
            end
         end
         2'd1: begin
            if ((held_lead_ff & 8'hE0) == 8'hC0) begin
               result.units  = u2h_pkg::UNITS_ONE;
               result.unit0  = {5'b00000, held_lead_ff[4:0], in_byte[5:0]};
               held_lead_in  = '0;
               held_count_in = 2'd0;
            end else if (in_last) begin
               // truncated three-byte sequence: '?' then the byte as a fresh lead
               result.units  = u2h_pkg::UNITS_TWO;
               result.unit0  = u2h_pkg::QMARK_UNIT;
               result.unit1  = (in_byte < u2h_pkg::ASCII_LIMIT) ? {8'h00, in_byte}
                                                               : u2h_pkg::QMARK_UNIT;
               held_lead_in  = '0;
               held_count_in = 2'd0;
            end else begin
               held_second_in = in_byte;
               held_count_in  = 2'd2;
            end
         end
         default: begin
            result.units   = u2h_pkg::UNITS_ONE;
            result.unit0   = {held_lead_ff[3:0], held_second_ff[5:0], in_byte[5:0]};
            held_lead_in   = '0;
            held_second_in = '0;
            held_count_in  = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff   <= '0;
         held_second_ff <= '0;
         held_count_ff  <= '0;
      end else if (fire) begin
         held_lead_ff   <= held_lead_in;
         held_second_ff <= held_second_in;
         held_count_ff  <= held_count_in;
      end
   end

endmodule

[rtl/u2h_serialize.sv]
// Nibble serializer: registers decoded code units and sends them through an output
// register as ASCII hex, one beat per cycle unless out_ready stalls. Uses u2h_pkg.
module u2h_serialize (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  u2h_pkg::dec_result_type        result,
   output logic                           ready,
   output u2h_pkg::ser_status_type        status,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [u2h_pkg::CHAR_W-1:0]     out_char,
   output logic                           out_last
);

   localparam int unsigned SHIFT_W = 2 * u2h_pkg::UNIT_W;

   logic [SHIFT_W-1:0]            nib_shift_ff, nib_shift_in;
   logic [u2h_pkg::NIB_CNT_W-1:0] nib_left_ff, nib_left_in;
   logic                          out_valid_ff, out_valid_in;
   logic [u2h_pkg::CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_free;
   logic                          emit;

   assign out_free = !out_valid_ff || out_ready;
   assign emit     = (nib_left_ff != '0) && out_free;
   assign ready    = (nib_left_ff == '0) ||
                     ((nib_left_ff == u2h_pkg::NIB_CNT_W'(1)) && out_free);

   always_comb begin
      nib_shift_in = nib_shift_ff;
      nib_left_in  = nib_left_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = u2h_pkg::hex_char(nib_shift_ff[SHIFT_W-1 -: 4]);
         out_last_in  = (nib_left_ff == u2h_pkg::NIB_CNT_W'(1));
         nib_shift_in = {nib_shift_ff[SHIFT_W-5:0], 4'h0};
         nib_left_in  = nib_left_ff - u2h_pkg::NIB_CNT_W'(1);
      end
      // load the next item's units behind the last nibble of this one
      if (load) begin
         nib_shift_in = {result.unit0, result.unit1};
         case (result.units)
            u2h_pkg::UNITS_ONE: nib_left_in = u2h_pkg::NIB_CNT_W'(4);
            u2h_pkg::UNITS_TWO: nib_left_in = u2h_pkg::NIB_CNT_W'(8);
            default:            nib_left_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nib_left_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         nib_left_ff  <= nib_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nib_shift_ff <= nib_shift_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

   assign out_valid       = out_valid_ff;
   assign out_char        = out_char_ff;
   assign out_last        = out_last_ff;
   assign status.out_free = out_free;
   assign status.nib_left = nib_left_ff;

endmodule

[rtl/utf8_to_ucs2_hex_core.sv]
// Top level of the UTF-8 to hex UCS-2 encoder.
// Instantiates u2h_decode and u2h_serialize; depends on u2h_pkg.
//
// Usage:
//   The req channel takes one UTF-8 byte per beat (req_tdata), with req_tlast
//   on the final byte of a string. The rsp channel returns uppercase ASCII hex
//   characters, four per decoded 16-bit code unit, most significant nibble
//   first; rsp_tlast marks the last character caused by one input byte.
//   A byte that only extends a held sequence produces no beat at all.
//   The first character of a byte passes the nibble shift register and then the
//   output register before it appears on rsp. Throughput: one character per cycle
//   on rsp while rsp_tready is high; a byte yielding one code unit gives four
//   characters, a truncated three-byte sequence at end of string eight. Bytes
//   producing no output are taken every cycle while no nibbles are queued.
//   The next byte is taken in the cycle the current item's last character moves
//   into the output register, so the rsp channel streams without gaps across items.
//   Reset clears held sequence state and drops any characters still queued.
//   When rsp_tready is low the output register holds its beat and req_tready
//   falls as soon as the queued nibbles cannot advance.
module utf8_to_ucs2_hex_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] hex_char, [7] zero
   output logic       rsp_tlast    // out_last
);

   u2h_pkg::dec_result_type dec_result;
   u2h_pkg::ser_status_type ser_status;
   logic                    req_fire;
   logic                    ser_ready;
   logic [u2h_pkg::CHAR_W-1:0] rsp_char;

   assign req_tready = ser_ready;
   assign req_fire   = req_tvalid && ser_ready;

   u2h_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (req_fire),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .result  (dec_result)
   );

   u2h_serialize u_serialize (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .result    (dec_result),
      .ready     (ser_ready),
      .status    (ser_status),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_char),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

   // A byte that yields code units must leave nibbles queued next cycle
   a_load_queues: assert property (@(posedge clock) disable iff (reset)
      req_fire && (dec_result.units != u2h_pkg::UNITS_NONE) |=> ser_status.nib_left != '0)
      else $error("decoded units were not queued");

   // Never more than two code units queued
   a_nib_bound: assert property (@(posedge clock) disable iff (reset)
      ser_status.nib_left <= u2h_pkg::NIB_CNT_W'(8))
      else $error("nibble count out of range");

   // Every character sent is an uppercase hex digit
   a_hex_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
                     (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h46))
      else $error("output is not a hex digit");

   // Taking a byte while nibbles remain needs the last one to leave now
   a_accept_drain: assert property (@(posedge clock) disable iff (reset)
      req_fire && (ser_status.nib_left != '0) |-> ser_status.out_free &&
                                               (ser_status.nib_left == u2h_pkg::NIB_CNT_W'(1)))
      else $error("byte accepted over queued nibbles");

endmodule
